// ===== hw/rtl/dmdf_pkg.sv =====
// shared types and constants of the duplicate filter
`default_nettype none
package dmdf_pkg;

  localparam int DIGEST_W  = 128;
  localparam int HALF_W    = 64;
  localparam int SUM_W     = 32;
  localparam int QUO_W     = 12;
  localparam int RED_STEPS = 5;
  localparam int CNT_W     = 3;

  localparam logic [1:0] REQ_INSERT    = 2'd0;
  localparam logic [1:0] REQ_CLEAR_ONE = 2'd1;
  localparam logic [1:0] REQ_CLEAR_ALL = 2'd2;

  typedef struct packed {
    logic [1:0]        req;
    logic [HALF_W-1:0] digest_high;
    logic [HALF_W-1:0] digest_low;
  } item_t;

  typedef struct packed {
    logic init_done;
  } back_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dmdf_front.sv =====
// front end: accepts requests and reduces the digest to a slot index
`default_nettype none
module dmdf_front #(
  parameter int ENTRIES = 1024,
  parameter int IDX_W   = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [127:0]          in_tdata,
  input  wire logic [1:0]            in_tuser,
  input  wire dmdf_pkg::back_status_t status,
  output logic                       push,
  input  wire logic                  push_ready,
  output dmdf_pkg::item_t            push_item,
  output logic [IDX_W-1:0]           push_idx
);
  import dmdf_pkg::*;

  localparam bit IS_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

  function automatic logic [SUM_W-1:0] byte_weight(input int pos);
    logic [SUM_W-1:0] w;
    w = SUM_W'(1);
    for (int k = 0; k < 8 * pos; k++) begin
      w = w << 1;
      if (w >= SUM_W'(ENTRIES)) begin
        w = w - SUM_W'(ENTRIES);
      end
    end
    return w;
  endfunction

  item_t hold_r;
  logic  hold_valid_r;
  logic  done;
  logic  accept;

  assign push      = hold_valid_r && done && push_ready;
  assign in_tready = status.init_done && (!hold_valid_r || push);
  assign accept    = in_tvalid && in_tready;
  assign push_item = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept) begin
      hold_valid_r <= 1'b1;
    end else if (push) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r.req         <= in_tuser;
      hold_r.digest_high <= in_tdata[63:0];
      hold_r.digest_low  <= in_tdata[127:64];
    end
  end

  generate
    if (ENTRIES == 1) begin : g_single
      assign done     = 1'b1;
      assign push_idx = '0;
    end else if (IS_POW2) begin : g_pow2
      assign done     = 1'b1;
      assign push_idx = hold_r.digest_low[IDX_W-1:0];
    end else begin : g_iter
      localparam int PROD_W = 2 * SUM_W;
      localparam int DIFF_W = IDX_W + 1;
      localparam logic [SUM_W-1:0]  RECIP = SUM_W'((64'd1 << SUM_W) / 64'(ENTRIES));
      localparam logic [DIFF_W-1:0] MODD  = DIFF_W'(ENTRIES);

      logic [CNT_W-1:0]    cnt_r;
      logic [DIGEST_W-1:0] dig;
      logic [SUM_W-1:0]    prod [16];
      logic [SUM_W-1:0]    part_r [4];
      logic [SUM_W-1:0]    sum_r;
      logic [PROD_W-1:0]   qprod;
      logic [QUO_W-1:0]    quo_r;
      logic [SUM_W-1:0]    diff;
      logic [DIFF_W-1:0]   diff_r;
      logic [IDX_W-1:0]    rem_r;

      assign done     = (cnt_r == CNT_W'(RED_STEPS));
      assign push_idx = rem_r;
      assign dig      = {hold_r.digest_high, hold_r.digest_low};
      assign qprod    = PROD_W'(sum_r) * PROD_W'(RECIP);
      assign diff     = sum_r - SUM_W'(quo_r) * SUM_W'(ENTRIES);

      // each digest byte weighted by its residue of 2^(8*pos)
      for (genvar b = 0; b < 16; b++) begin : g_prod
        localparam logic [SUM_W-1:0] WB = byte_weight(b);
        assign prod[b] = SUM_W'(dig[8*b +: 8]) * WB;
      end

      // weighted sum, reciprocal quotient estimate, one final correction
      always_ff @(posedge clk) begin
        for (int g = 0; g < 4; g++) begin
          part_r[g] <= prod[4*g] + prod[4*g+1] + prod[4*g+2] + prod[4*g+3];
        end
        sum_r  <= part_r[0] + part_r[1] + part_r[2] + part_r[3];
        quo_r  <= qprod[SUM_W +: QUO_W];
        diff_r <= diff[DIFF_W-1:0];
        rem_r  <= (diff_r >= MODD) ? IDX_W'(diff_r - MODD) : diff_r[IDX_W-1:0];
      end

      always_ff @(posedge clk) begin
        if (accept) begin
          cnt_r <= '0;
        end else if (hold_valid_r && !done) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  endgenerate

endmodule
`default_nettype wire

// ===== hw/rtl/dmdf_queue.sv =====
// small fifo between front and back
`default_nettype none
module dmdf_queue #(
  parameter int WIDTH = 140,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [AW-1:0]    wptr_r;
  logic [AW-1:0]    rptr_r;
  logic [CW-1:0]    count_r;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = store_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (rd_en) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dmdf_back.sv =====
// back end: digest table, lookup, update and clearing sweeps
`default_nettype none
module dmdf_back #(
  parameter int ENTRIES = 1024,
  parameter int IDX_W   = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  output logic                  q_pop,
  input  wire dmdf_pkg::item_t  q_item,
  input  wire logic [IDX_W-1:0] q_idx,
  output dmdf_pkg::back_status_t status,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata
);
  import dmdf_pkg::*;

  typedef enum logic [3:0] {
    S_INIT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RESP  = 4'b0100,
    S_SWEEP = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  logic [DIGEST_W-1:0] mem [ENTRIES];

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  item_t               cur_r;
  logic [IDX_W-1:0]    cur_idx_r;
  logic [DIGEST_W-1:0] rd_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_existed_r, out_existed_nxt;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [DIGEST_W-1:0] wdata;
  logic                match;
  logic                can_out;

  assign match            = (rd_r == {cur_r.digest_high, cur_r.digest_low});
  assign can_out          = !out_valid_r || out_tready;
  assign q_pop            = q_valid && (state_r == S_IDLE);
  assign status.init_done = (state_r != S_INIT);
  assign out_tvalid       = out_valid_r;
  assign out_tdata        = {7'b0, out_existed_r};

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_existed_nxt = out_existed_r;
    we              = 1'b0;
    waddr           = cur_idx_r;
    wdata           = {cur_r.digest_high, cur_r.digest_low};
    case (state_r)
      S_INIT: begin
        we    = 1'b1;
        waddr = cnt_r;
        wdata = '0;
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          cnt_nxt   = '0;
          state_nxt = (q_item.req == REQ_CLEAR_ALL) ? S_SWEEP : S_RESP;
        end
      end
      S_SWEEP: begin
        we    = 1'b1;
        waddr = cnt_r;
        wdata = '0;
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == LAST) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (can_out) begin
          out_valid_nxt   = 1'b1;
          out_existed_nxt = (cur_r.req == REQ_INSERT) && match;
          state_nxt       = S_IDLE;
          if (cur_r.req == REQ_INSERT) begin
            we = !match;
          end else if (cur_r.req == REQ_CLEAR_ONE) begin
            we    = match;
            wdata = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_existed_r <= out_existed_nxt;
    if (q_pop) begin
      cur_r     <= q_item;
      cur_idx_r <= q_idx;
    end
  end

  // table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (q_pop) begin
      rd_r <= mem[q_idx];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/direct_mapped_duplicate_filter.sv =====
// top level of the direct-mapped duplicate filter
// Each request carries a 128-bit digest whose table slot is the digest modulo
// ENTRIES. Check-and-insert answers existed 1 when the slot holds the digest and
// otherwise overwrites it; clear-one zeroes a slot holding the digest; clear-all
// zeroes the table; every request gets exactly one response. The front end reduces
// the digest to a slot index: when ENTRIES is a power of two this is a bit select,
// otherwise a remainder unit that sums the digest bytes weighted by constant
// residues and reduces the sum with a reciprocal multiply. The back end works on
// one request at a time through a table with one write port and a registered
// read port. A clear-all occupies the back end while it sweeps the table, one
// slot per cycle. After reset the table is swept to zero and no request is
// accepted until that is done.
`default_nettype none
module direct_mapped_duplicate_filter #(
  parameter int ENTRIES = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // digest_low, digest_high
  input  wire logic [1:0]   in_tuser,   // req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata   // existed, zero fill
);
  import dmdf_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QW    = IDX_W + $bits(item_t);

  back_status_t     status;
  logic             push;
  logic             push_ready;
  item_t            push_item;
  logic [IDX_W-1:0] push_idx;
  logic             q_valid;
  logic             q_pop;
  logic [QW-1:0]    q_data;
  item_t            q_item;
  logic [IDX_W-1:0] q_idx;

  assign q_item = q_data[$bits(item_t)-1:0];
  assign q_idx  = q_data[QW-1:$bits(item_t)];

  dmdf_front #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .status     (status),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .push_idx   (push_idx)
  );

  dmdf_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_ready (push_ready),
    .wr_data  ({push_idx, push_item}),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_data)
  );

  dmdf_back #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .q_idx      (q_idx),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== test/tb_direct_mapped_duplicate_filter.sv =====
// self-checking testbench of the direct-mapped duplicate filter
`timescale 1ns / 1ps
module tb_direct_mapped_duplicate_filter;
  import dmdf_pkg::*;

  localparam int ENTRIES = 1024;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_PCT = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE = 64;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // digest_low, digest_high
  logic [1:0]   in_tuser = '0;   // req_type
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;       // existed, zero fill

  direct_mapped_duplicate_filter #(.ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [63:0]  slot_hi [ENTRIES];
  logic [63:0]  slot_lo [ENTRIES];
  logic [127:0] digest_pool [POOL_SIZE];
  logic [9:0]   hot_slots [16];
  item_t        pending_reqs [$];
  logic [7:0]   existed_due [$];
  int           accept_count = 0;
  int           issued_count = 0;
  int           error_count = 0;
  bit           hold_req = 1'b0;
  bit           hold_ack = 1'b0;
  int           hold_left = 0;
  wire          calm_window = (accept_count >= 500) && (accept_count < 700);

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic bit lookup_and_update(logic [1:0] req, logic [63:0] hi, logic [63:0] lo);
    logic [127:0] digest;
    int unsigned  idx;
    bit           hit;
    digest = {hi, lo};
    idx = int'(digest % 128'(ENTRIES));
    hit = (slot_hi[idx] == hi) && (slot_lo[idx] == lo);
    case (req)
      REQ_INSERT: begin
        if (!hit) begin
          slot_hi[idx] = hi;
          slot_lo[idx] = lo;
        end
        return hit;
      end
      REQ_CLEAR_ONE: begin
        if (hit) begin
          slot_hi[idx] = '0;
          slot_lo[idx] = '0;
        end
      end
      REQ_CLEAR_ALL: begin
        for (int k = 0; k < ENTRIES; k++) begin
          slot_hi[k] = '0;
          slot_lo[k] = '0;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic bit all_drained();
    return pending_reqs.size() == 0 && accept_count == issued_count && existed_due.size() == 0;
  endfunction

  task automatic queue_req(input logic [1:0] req, input logic [63:0] hi, input logic [63:0] lo);
    item_t it;
    it.req = req;
    it.digest_high = hi;
    it.digest_low = lo;
    pending_reqs.push_back(it);
  endtask

  task automatic queue_random(input int count);
    int          pick;
    logic [127:0] d;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      d = digest_pool[$urandom_range(POOL_SIZE - 1)];
      if (pick < 56) queue_req(REQ_INSERT, d[127:64], d[63:0]);
      else if (pick < 70) queue_req(REQ_INSERT, {$urandom, $urandom}, {$urandom, $urandom});
      else if (pick < 88) queue_req(REQ_CLEAR_ONE, d[127:64], d[63:0]);
      else if (pick < 90) queue_req(REQ_CLEAR_ALL, {$urandom, $urandom}, {$urandom, $urandom});
      else if (pick < 94) queue_req(REQ_UNUSED, {$urandom, $urandom}, {$urandom, $urandom});
      else queue_req(REQ_CLEAR_ONE, {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  // sender
  always @(negedge clk) begin : send_side
    item_t next_req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || accept_count == issued_count) begin
      if (pending_reqs.size() != 0 && (calm_window || $urandom_range(99) >= IDLE_PCT)) begin
        next_req = pending_reqs.pop_front();
        in_tdata <= {next_req.digest_low, next_req.digest_high};
        in_tuser <= next_req.req;
        in_tvalid <= 1'b1;
        issued_count <= issued_count + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm_window || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_side
    logic [7:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (existed_due.size() == 0) begin
          report_error($sformatf("response 0x%02h with no request outstanding", out_tdata));
        end else begin
          want = existed_due.pop_front();
          if (out_tdata[0] !== want[0])
            report_error($sformatf("existed got %b want %b", out_tdata[0], want[0]));
          if (out_tdata[7:1] !== want[7:1])
            report_error($sformatf("fill bits got 0x%02h want 0", out_tdata[7:1]));
        end
      end
      if (in_tvalid && in_tready) begin
        existed_due.push_back({7'd0, lookup_and_update(in_tuser, in_tdata[63:0], in_tdata[127:64])});
        accept_count <= accept_count + 1;
      end
    end
  end

  initial begin
    #1_600_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int k = 0; k < ENTRIES; k++) begin
      slot_hi[k] = '0;
      slot_lo[k] = '0;
    end
    for (int k = 0; k < 16; k++) hot_slots[k] = 10'($urandom);
    for (int k = 0; k < POOL_SIZE; k++) begin
      digest_pool[k] = {$urandom, $urandom, $urandom, $urandom};
      digest_pool[k][9:0] = hot_slots[$urandom_range(15)];
      if ($urandom_range(7) == 0) digest_pool[k][127:64] = '0;
      if ($urandom_range(15) == 0) digest_pool[k] = '0;
    end

    // zero digest, extremes, collisions, clear-one, unused code, clear-all
    queue_req(REQ_INSERT, '0, '0);
    queue_req(REQ_INSERT, '1, '1);
    queue_req(REQ_INSERT, '1, '1);
    queue_req(REQ_INSERT, 64'd1, '1);
    queue_req(REQ_INSERT, '1, '1);
    queue_req(REQ_CLEAR_ONE, 64'd1, '1);
    queue_req(REQ_CLEAR_ONE, '1, '1);
    queue_req(REQ_INSERT, '1, '1);
    queue_req(REQ_CLEAR_ONE, '0, '0);
    queue_req(REQ_UNUSED, '1, '1);
    queue_req(REQ_INSERT, '1, '1);
    queue_req(REQ_INSERT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    queue_req(REQ_INSERT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    queue_req(REQ_CLEAR_ALL, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    queue_req(REQ_INSERT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    queue_req(REQ_INSERT, '1, '1);
    queue_req(REQ_INSERT, 64'h8000_0000_0000_0000, '0);
    queue_req(REQ_INSERT, '0, '0);
    queue_req(REQ_INSERT, 64'h8000_0000_0000_0000, '0);
    queue_req(REQ_INSERT, '0, 64'h0000_0000_0000_0400);
    queue_req(REQ_CLEAR_ALL, '1, '1);
    queue_req(REQ_INSERT, '1, '1);
    queue_req(REQ_UNUSED, '0, '0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // sender pause until every response is back
    while (!all_drained()) @(posedge clk);

    queue_random(400);
    while (pending_reqs.size() >= 300) @(posedge clk);
    @(negedge clk);
    hold_req <= ~hold_req;
    queue_random(700);

    while (!all_drained()) @(posedge clk);
    repeat (ENTRIES + 20) @(posedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
